// ----- rtl/csms_pkg.sv -----
`default_nettype none

package csms_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned DWORD_W = 2 * WORD_W;
    localparam int unsigned SHIFT_W = 6;
    localparam int unsigned CNT_W   = 6;

    localparam logic [SHIFT_W-1:0] SHIFT_MAX  = SHIFT_W'(WORD_W);
    localparam logic [SHIFT_W-1:0] SHIFT_MIN  = SHIFT_W'(1);
    localparam logic [SHIFT_W-1:0] SHIFT_NONE = SHIFT_W'(0);
    localparam logic [CNT_W-1:0]   DIV_LAST   = CNT_W'(DWORD_W - 1);

    // controller to datapath
    typedef struct packed {
        logic               load;       // capture request fields
        logic               mul;        // span * source, keep high word
        logic               head_step;  // one bit of headroom search
        logic               div_init;   // form rounded numerator for trial shift
        logic               div_step;   // one restoring division step
        logic               out_load;   // move result into output register
        logic [SHIFT_W-1:0] trial_shift;
        logic [SHIFT_W-1:0] res_shift;
    } csms_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic acc_zero;
        logic fits;
    } csms_sts_t;

endpackage

`default_nettype wire

// ----- rtl/csms_if.sv -----
`default_nettype none

interface csms_req_if;
    import csms_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] source_hz;
    logic [WORD_W-1:0] target_hz;
    logic [WORD_W-1:0] span_seconds;

    modport source (output valid, source_hz, target_hz, span_seconds, input ready);
    modport sink   (input valid, source_hz, target_hz, span_seconds, output ready);
endinterface

interface csms_rsp_if;
    import csms_pkg::*;

    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  multiplier;
    logic [SHIFT_W-1:0] shift_amount;

    modport source (output valid, multiplier, shift_amount, input ready);
    modport sink   (input valid, multiplier, shift_amount, output ready);
endinterface

`default_nettype wire

// ----- rtl/csms_ctrl.sv -----
`default_nettype none

module csms_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    input  wire csms_pkg::csms_sts_t   sts,
    output csms_pkg::csms_cmd_t        cmd
);
    import csms_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_HEAD,
        ST_INIT,
        ST_DIV,
        ST_CHECK,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [SHIFT_W-1:0] res_shift_reg, res_shift_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               slot_free;

    assign slot_free = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        res_shift_next = res_shift_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !rsp_ready;

        cmd             = '0;
        cmd.trial_shift = shift_reg;
        cmd.res_shift   = res_shift_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_HEAD;
            end
            ST_HEAD:
            begin
                if (sts.acc_zero)
                begin
                    shift_next = SHIFT_MAX;
                    state_next = ST_INIT;
                end
                else
                begin
                    cmd.head_step = 1'b1;
                end
            end
            ST_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = DIV_LAST;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_CHECK;
                else
                    cnt_next = cnt_reg - CNT_W'(1);
            end
            ST_CHECK:
            begin
                priority if (sts.fits)
                begin
                    res_shift_next = shift_reg;
                    state_next     = ST_DONE;
                end
                else if (shift_reg == SHIFT_MIN)
                begin
                    // nothing fitted: keep the last quotient, report no shift
                    res_shift_next = SHIFT_NONE;
                    state_next     = ST_DONE;
                end
                else
                begin
                    shift_next = shift_reg - SHIFT_W'(1);
                    state_next = ST_INIT;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            shift_reg     <= '0;
            res_shift_reg <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shift_reg     <= shift_next;
            res_shift_reg <= res_shift_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/csms_dpath.sv -----
`default_nettype none

module csms_dpath (
    input  wire logic                         clk,
    input  wire logic [csms_pkg::WORD_W-1:0]  source_hz,
    input  wire logic [csms_pkg::WORD_W-1:0]  target_hz,
    input  wire logic [csms_pkg::WORD_W-1:0]  span_seconds,
    input  wire csms_pkg::csms_cmd_t          cmd,
    output csms_pkg::csms_sts_t               sts,
    output logic [csms_pkg::WORD_W-1:0]       multiplier,
    output logic [csms_pkg::SHIFT_W-1:0]      shift_amount
);
    import csms_pkg::*;

    logic [WORD_W-1:0]  src_reg, dst_reg, span_reg;
    logic [WORD_W-1:0]  acc_reg, acc_next;
    logic [SHIFT_W-1:0] head_reg, head_next;
    logic [DWORD_W-1:0] num_reg, num_next;   // numerator, fills with quotient
    logic [WORD_W-1:0]  rem_reg, rem_next;
    logic [WORD_W-1:0]  mult_reg;
    logic [SHIFT_W-1:0] shout_reg;

    logic [DWORD_W-1:0] product;
    logic [DWORD_W-1:0] numer;
    logic [WORD_W:0]    rem_sh;
    logic [WORD_W:0]    rem_diff;
    logic               rem_ge;

    assign product  = DWORD_W'(span_reg) * DWORD_W'(src_reg);
    assign numer    = (DWORD_W'(dst_reg) << cmd.trial_shift) + DWORD_W'(src_reg >> 1);
    assign rem_sh   = {rem_reg, num_reg[DWORD_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, src_reg};
    assign rem_diff = rem_sh - {1'b0, src_reg};

    always_comb
    begin
        acc_next  = acc_reg;
        head_next = head_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;

        if (cmd.mul)
        begin
            acc_next  = product[DWORD_W-1:WORD_W];
            head_next = SHIFT_MAX;
        end
        if (cmd.head_step)
        begin
            acc_next  = acc_reg >> 1;
            head_next = head_reg - SHIFT_W'(1);
        end
        if (cmd.div_init)
        begin
            num_next = numer;
            rem_next = '0;
        end
        if (cmd.div_step)
        begin
            // zero divisor always subtracts, so the quotient comes out all ones
            num_next = {num_reg[DWORD_W-2:0], rem_ge};
            rem_next = rem_ge ? rem_diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            src_reg  <= source_hz;
            dst_reg  <= target_hz;
            span_reg <= span_seconds;
        end
        acc_reg  <= acc_next;
        head_reg <= head_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        if (cmd.out_load)
        begin
            mult_reg  <= num_reg[WORD_W-1:0];
            shout_reg <= cmd.res_shift;
        end
    end

    assign sts.acc_zero = (acc_reg == '0);
    assign sts.fits     = ((num_reg >> head_reg) == '0);

    assign multiplier   = mult_reg;
    assign shift_amount = shout_reg;

endmodule

`default_nettype wire

// ----- rtl/clock_scale_mult_shift.sv -----
// Multiplier and shift for converting counts at one rate into units of another.
// A request runs a headroom search over h = bit length of (span*source)>>32
// (0..32), then t trial shifts (1..32), each a division by the one-bit-per-cycle
// 64-bit restoring divider. A new request is accepted only in idle, after the
// result is moved to the output register, which waits for the last one to go.
// Reset clears the controller and the output valid; no other state.
`default_nettype none

module clock_scale_mult_shift (
    input  wire logic  clk,
    input  wire logic  rst_n,
    csms_req_if.sink   req,
    csms_rsp_if.source rsp
);
    import csms_pkg::*;

    csms_cmd_t cmd;
    csms_sts_t sts;

    csms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    csms_dpath u_dpath (
        .clk          (clk),
        .source_hz    (req.source_hz),
        .target_hz    (req.target_hz),
        .span_seconds (req.span_seconds),
        .cmd          (cmd),
        .sts          (sts),
        .multiplier   (rsp.multiplier),
        .shift_amount (rsp.shift_amount)
    );

endmodule

`default_nettype wire
